FILE: hdl/rplc_pkg.sv
// Shared types and constants for the pulse light controller.
package rplc_pkg;

  localparam int unsigned PULSE_W = 12;
  localparam int unsigned CMP_W = 14;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_STEER_CENTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_DEAD_ZONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_CENTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_DEAD_ZONE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_INTERVAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_HOLD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GLITCH_FLOOR = 3'd6;

  localparam logic [11:0] RST_STEER_CENTER = 12'd1505;
  localparam logic [9:0] RST_STEER_DEAD_ZONE = 10'd30;
  localparam logic [11:0] RST_THROTTLE_CENTER = 12'd1493;
  localparam logic [9:0] RST_THROTTLE_DEAD_ZONE = 10'd8;
  localparam logic [15:0] RST_BLINK_INTERVAL = 16'd500;
  localparam logic [15:0] RST_BRAKE_HOLD = 16'd250;
  localparam logic [11:0] RST_GLITCH_FLOOR = 12'd1100;

  typedef enum logic [1:0] {
    ZONE_CENTRE = 2'd0,
    ZONE_LEFT = 2'd1,
    ZONE_RIGHT = 2'd2
  } zone_e;

  typedef struct packed {
    logic [11:0] steer_center;
    logic [9:0] steer_dead_zone;
    logic [11:0] throttle_center;
    logic [9:0] throttle_dead_zone;
    logic [15:0] blink_interval;
    logic [15:0] brake_hold;
    logic [11:0] glitch_floor;
  } cfg_t;

  typedef struct packed {
    zone_e szone;
    logic reverse;
    logic brake_set;
    logic brake_clr;
    logic [PULSE_W-1:0] throttle;
  } cls_t;

  typedef struct packed {
    logic left;
    logic right;
    logic brake;
    logic reverse;
  } lamps_t;

endpackage

FILE: hdl/rplc_classify.sv
// Pulse cleanup, zone classification and brake decision for one item.
module rplc_classify #(
  parameter int unsigned PULSE_BITS = 12
) (
  input  rplc_pkg::cfg_t                     cfg_i,
  input  logic [rplc_pkg::PULSE_W-1:0]       steer_i,
  input  logic [rplc_pkg::PULSE_W-1:0]       throttle_i,
  input  logic [rplc_pkg::PULSE_W-1:0]       last_throttle_i,
  output rplc_pkg::cls_t                     cls_o
);

  localparam int unsigned SAT_W = 17;
  localparam logic [SAT_W-1:0] PULSE_MAX = SAT_W'((32'd1 << PULSE_BITS) - 32'd1);

  logic [rplc_pkg::PULSE_W-1:0] steer_sat;
  logic [rplc_pkg::PULSE_W-1:0] thr_sat;
  logic [rplc_pkg::PULSE_W-1:0] sv;
  logic [rplc_pkg::PULSE_W-1:0] tv;
  logic signed [rplc_pkg::CMP_W-1:0] sv_s, tv_s, sc_s, sd_s, tc_s, td_s, last_s;
  logic below, above, fwd, rev_zone;

  always_comb begin
    steer_sat = (SAT_W'(steer_i) > PULSE_MAX) ? PULSE_MAX[rplc_pkg::PULSE_W-1:0] : steer_i;
    thr_sat = (SAT_W'(throttle_i) > PULSE_MAX) ? PULSE_MAX[rplc_pkg::PULSE_W-1:0]
                                                : throttle_i;
    if ((steer_sat == '0) || (thr_sat == '0) || (thr_sat < cfg_i.glitch_floor)) begin
      sv = cfg_i.steer_center;
      tv = cfg_i.throttle_center;
    end else begin
      sv = steer_sat;
      tv = thr_sat;
    end

    sv_s = $signed(rplc_pkg::CMP_W'(sv));
    tv_s = $signed(rplc_pkg::CMP_W'(tv));
    sc_s = $signed(rplc_pkg::CMP_W'(cfg_i.steer_center));
    sd_s = $signed(rplc_pkg::CMP_W'(cfg_i.steer_dead_zone));
    tc_s = $signed(rplc_pkg::CMP_W'(cfg_i.throttle_center));
    td_s = $signed(rplc_pkg::CMP_W'(cfg_i.throttle_dead_zone));
    last_s = $signed(rplc_pkg::CMP_W'(last_throttle_i));

    if (sv_s > sc_s + sd_s) begin
      cls_o.szone = rplc_pkg::ZONE_RIGHT;
    end else if (sv_s < sc_s - sd_s) begin
      cls_o.szone = rplc_pkg::ZONE_LEFT;
    end else begin
      cls_o.szone = rplc_pkg::ZONE_CENTRE;
    end

    fwd = tv_s > tc_s + td_s;
    rev_zone = tv_s < tc_s - td_s;
    cls_o.reverse = !fwd && rev_zone;

    below = (tv_s + td_s) < last_s;
    above = (tv_s - td_s) > last_s;
    cls_o.brake_set = (below && fwd) || (!below && above && rev_zone);
    cls_o.brake_clr = (below && !fwd) || (!below && !above);
    cls_o.throttle = tv;
  end

endmodule

FILE: hdl/rplc_lamp_state.sv
// Blink and brake state registers with the lamp drive logic.
module rplc_lamp_state #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  rplc_pkg::cfg_t                cfg_i,
  input  rplc_pkg::cls_t                cls_i,
  input  logic [TIME_BITS-1:0]          now_i,
  output logic [rplc_pkg::PULSE_W-1:0]  last_throttle_o,
  output rplc_pkg::lamps_t              lamps_o
);

  rplc_pkg::zone_e last_zone_q, last_zone_d;
  logic left_phase_q, left_phase_d;
  logic right_phase_q, right_phase_d;
  logic [TIME_BITS-1:0] blink_start_q, blink_start_d;
  logic brake_active_q, brake_active_d;
  logic [TIME_BITS-1:0] brake_start_q, brake_start_d;
  logic brake_started_q, brake_started_d;
  logic [rplc_pkg::PULSE_W-1:0] last_throttle_q, last_throttle_d;
  logic [TIME_BITS-1:0] blink_elapsed;
  logic [TIME_BITS-1:0] brake_elapsed;
  logic blink_due;

  always_comb begin
    left_phase_d = left_phase_q;
    right_phase_d = right_phase_q;
    blink_start_d = blink_start_q;
    brake_active_d = brake_active_q;
    brake_start_d = brake_start_q;
    brake_started_d = brake_started_q;
    blink_elapsed = now_i - blink_start_q;
    blink_due = blink_elapsed > TIME_BITS'(cfg_i.blink_interval);

    case (cls_i.szone)
      rplc_pkg::ZONE_LEFT: begin
        if (last_zone_q != rplc_pkg::ZONE_LEFT) begin
          left_phase_d = 1'b1;
          blink_start_d = now_i;
        end else if (blink_due) begin
          left_phase_d = !left_phase_q;
          blink_start_d = now_i;
        end
      end
      rplc_pkg::ZONE_RIGHT: begin
        if (last_zone_q != rplc_pkg::ZONE_RIGHT) begin
          right_phase_d = 1'b1;
          blink_start_d = now_i;
        end else if (blink_due) begin
          right_phase_d = !right_phase_q;
          blink_start_d = now_i;
        end
      end
      default: begin
      end
    endcase
    last_zone_d = cls_i.szone;

    if (cls_i.brake_set) begin
      brake_active_d = 1'b1;
      brake_start_d = now_i;
      brake_started_d = 1'b1;
    end else if (cls_i.brake_clr) begin
      brake_active_d = 1'b0;
    end
    last_throttle_d = cls_i.throttle;

    brake_elapsed = now_i - brake_start_d;
    lamps_o.left = (cls_i.szone == rplc_pkg::ZONE_LEFT) && left_phase_d;
    lamps_o.right = (cls_i.szone == rplc_pkg::ZONE_RIGHT) && right_phase_d;
    lamps_o.brake = brake_active_d ||
                    (brake_started_d && (brake_elapsed < TIME_BITS'(cfg_i.brake_hold)));
    lamps_o.reverse = cls_i.reverse;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_zone_q <= rplc_pkg::ZONE_CENTRE;
      left_phase_q <= 1'b0;
      right_phase_q <= 1'b0;
      blink_start_q <= '0;
      brake_active_q <= 1'b0;
      brake_start_q <= '0;
      brake_started_q <= 1'b0;
      last_throttle_q <= rplc_pkg::RST_THROTTLE_CENTER;
    end else if (step_i) begin
      last_zone_q <= last_zone_d;
      left_phase_q <= left_phase_d;
      right_phase_q <= right_phase_d;
      blink_start_q <= blink_start_d;
      brake_active_q <= brake_active_d;
      brake_start_q <= brake_start_d;
      brake_started_q <= brake_started_d;
      last_throttle_q <= last_throttle_d;
    end
  end

  assign last_throttle_o = last_throttle_q;

endmodule

FILE: hdl/rc_pulse_light_controller.sv
// Top level of the pulse light controller: handshake, registers and result stage.
// Each item passes an input register and then a result register, from which its result
// is presented. One item is accepted every cycle while the output is not stalled.
// All cleanup, zone sorting, blink and brake decisions for an item are made
// combinationally between those two registers, where the blink and brake state
// is also updated. Configuration registers take effect on the next item and should
// be written only while no item is in flight.
module rc_pulse_light_controller #(
  parameter int unsigned PULSE_BITS = 12,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [11:0]                       steer_width_i,
  input  logic [11:0]                       throttle_width_i,
  input  logic [31:0]                       now_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              left_lamp_o,
  output logic                              right_lamp_o,
  output logic                              brake_lamp_o,
  output logic                              reverse_lamp_o,
  input  logic                              cfg_we_i,
  input  logic [rplc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rplc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  rplc_pkg::cfg_t cfg_q;
  logic s1_valid_q, s1_valid_d;
  logic [rplc_pkg::PULSE_W-1:0] steer_q, throttle_q;
  logic [TIME_BITS-1:0] now_q;
  logic out_valid_q, out_valid_d;
  rplc_pkg::lamps_t lamps_q, lamps_d;
  rplc_pkg::cls_t cls;
  logic [rplc_pkg::PULSE_W-1:0] last_throttle;
  logic advance, step, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steer_center <= rplc_pkg::RST_STEER_CENTER;
      cfg_q.steer_dead_zone <= rplc_pkg::RST_STEER_DEAD_ZONE;
      cfg_q.throttle_center <= rplc_pkg::RST_THROTTLE_CENTER;
      cfg_q.throttle_dead_zone <= rplc_pkg::RST_THROTTLE_DEAD_ZONE;
      cfg_q.blink_interval <= rplc_pkg::RST_BLINK_INTERVAL;
      cfg_q.brake_hold <= rplc_pkg::RST_BRAKE_HOLD;
      cfg_q.glitch_floor <= rplc_pkg::RST_GLITCH_FLOOR;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rplc_pkg::REG_STEER_CENTER: cfg_q.steer_center <= cfg_data_i[11:0];
        rplc_pkg::REG_STEER_DEAD_ZONE: cfg_q.steer_dead_zone <= cfg_data_i[9:0];
        rplc_pkg::REG_THROTTLE_CENTER: cfg_q.throttle_center <= cfg_data_i[11:0];
        rplc_pkg::REG_THROTTLE_DEAD_ZONE: cfg_q.throttle_dead_zone <= cfg_data_i[9:0];
        rplc_pkg::REG_BLINK_INTERVAL: cfg_q.blink_interval <= cfg_data_i[15:0];
        rplc_pkg::REG_BRAKE_HOLD: cfg_q.brake_hold <= cfg_data_i[15:0];
        rplc_pkg::REG_GLITCH_FLOOR: cfg_q.glitch_floor <= cfg_data_i[11:0];
        default: begin
        end
      endcase
    end
  end

  assign advance = !out_valid_q || !out_stall_i;
  assign step = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept = in_valid_i && !in_stall_o;
  assign s1_valid_d = accept || (s1_valid_q && !advance);
  assign out_valid_d = step || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      steer_q <= steer_width_i;
      throttle_q <= throttle_width_i;
      now_q <= now_ms_i[TIME_BITS-1:0];
    end
    if (step) begin
      lamps_q <= lamps_d;
    end
  end

  rplc_classify #(
    .PULSE_BITS(PULSE_BITS)
  ) u_classify (
    .cfg_i          (cfg_q),
    .steer_i        (steer_q),
    .throttle_i     (throttle_q),
    .last_throttle_i(last_throttle),
    .cls_o          (cls)
  );

  rplc_lamp_state #(
    .TIME_BITS(TIME_BITS)
  ) u_lamp_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .cfg_i          (cfg_q),
    .cls_i          (cls),
    .now_i          (now_q),
    .last_throttle_o(last_throttle),
    .lamps_o        (lamps_d)
  );

  assign out_valid_o = out_valid_q;
  assign left_lamp_o = lamps_q.left;
  assign right_lamp_o = lamps_q.right;
  assign brake_lamp_o = lamps_q.brake;
  assign reverse_lamp_o = lamps_q.reverse;

endmodule
